FILE: rtl/core/hcbd_pkg.sv
package hcbd_pkg;

	// Most hex digits accepted on one size line
	localparam int SIZE_DIGITS = 8;
	localparam int RemW        = 4 * SIZE_DIGITS;
	localparam int DigitCntW   = $clog2(SIZE_DIGITS + 1);

	localparam logic [7:0] ChCr = 8'h0D;
	localparam logic [7:0] ChLf = 8'h0A;

	// Bytes skipped after each chunk's data
	localparam logic [1:0] SkipCount = 2'd2;

	typedef enum logic [2:0] {
		PH_SIZE    = 3'd0,
		PH_SIZE_CR = 3'd1,
		PH_BAD     = 3'd2,
		PH_BAD_CR  = 3'd3,
		PH_DATA    = 3'd4,
		PH_SKIP    = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		ST_RUN   = 2'd0,
		ST_OK    = 2'd1,
		ST_BAD   = 2'd2,
		ST_TRUNC = 2'd3
	} status_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] value;
	} hex_t;

	function automatic hex_t hex_decode(input logic [7:0] b);
		hex_t h;
		h.ok    = 1'b1;
		h.value = 4'h0;
		if (b >= 8'h30 && b <= 8'h39) begin
			h.value = 4'(b - 8'h30);
		end else if (b >= 8'h61 && b <= 8'h66) begin
			h.value = 4'(b - 8'h57);
		end else if (b >= 8'h41 && b <= 8'h46) begin
			h.value = 4'(b - 8'h37);
		end else begin
			h.ok = 1'b0;
		end
		return h;
	endfunction

endpackage

FILE: rtl/core/hcbd_ifs.sv
interface hcbd_in_if import hcbd_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_body;

	modport source (output valid, in_byte, end_of_body, input ready);
	modport sink (input valid, in_byte, end_of_body, output ready);
endinterface

interface hcbd_out_if import hcbd_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_valid;
	status_t    status;
	logic       last;

	modport source (output valid, out_byte, out_valid, status, last, input ready);
	modport sink (input valid, out_byte, out_valid, status, last, output ready);
endinterface

FILE: rtl/core/http_chunked_body_decoder.sv
// Channel  Dir  Payload                               Transaction when
// -------  ---  ------------------------------------  ---------------------
// din      in   in_byte[7:0], end_of_body             din.valid & din.ready
// dout     out  out_byte[7:0], out_valid, status[1:0], last
//                                                      dout.valid & dout.ready
//
// One byte per cycle: every byte is decoded in the cycle it is taken, by a
// small state update between the parser registers and the result register.
// A byte that yields a result lands in the result register the next cycle.
// arst_n clears the parser to the size-line phase and empties the result slot.
// din.ready stays high while the result slot is empty or being drained, so a
// stall on dout only holds din off while a result actually waits.
module http_chunked_body_decoder import hcbd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	hcbd_in_if.sink           din,
	hcbd_out_if.source        dout
);

	// Parser state
	phase_t               phase_q, phase_d;
	logic [RemW-1:0]      remaining_q, remaining_d;
	logic [DigitCntW-1:0] digit_count_q, digit_count_d;
	logic [1:0]           skip_left_q, skip_left_d;
	logic                 verdict_sent_q, verdict_sent_d;

	// Result register
	logic       res_valid_q;
	logic [7:0] res_byte_q;
	logic       res_data_q;
	status_t    res_status_q;
	logic       res_last_q;

	// Result of the current byte
	logic    have_data, have_verdict;
	status_t status_d;
	hex_t    hex;
	logic    take;
	logic    eob;
	logic [7:0] b;

	assign din.ready = !res_valid_q || dout.ready;
	assign take      = din.valid && din.ready;
	assign b         = din.in_byte;
	assign eob       = din.end_of_body;
	assign hex       = hex_decode(b);

	always_comb begin
		phase_d        = phase_q;
		remaining_d    = remaining_q;
		digit_count_d  = digit_count_q;
		skip_left_d    = skip_left_q;
		verdict_sent_d = verdict_sent_q;
		have_data      = 1'b0;
		have_verdict   = 1'b0;
		status_d       = ST_RUN;

		if (!verdict_sent_q) begin
			unique case (phase_q)
				PH_SIZE: begin
					if (b == ChCr) begin
						phase_d = PH_SIZE_CR;
					end else if (hex.ok && digit_count_q < DigitCntW'(SIZE_DIGITS)) begin
						// Shift in one digit; the top nibble falls off
						remaining_d   = RemW'({remaining_q, 4'h0}) | RemW'(hex.value);
						digit_count_d = digit_count_q + 1'b1;
					end else begin
						phase_d = PH_BAD;
					end
				end
				PH_SIZE_CR: begin
					if (b == ChLf) begin
						if (digit_count_q == '0) begin
							have_verdict = 1'b1;
							status_d     = ST_BAD;
						end else if (remaining_q == '0) begin
							have_verdict = 1'b1;
							status_d     = ST_OK;
						end else begin
							phase_d = PH_DATA;
						end
					end else if (b == ChCr) begin
						phase_d = PH_BAD_CR;
					end else begin
						phase_d = PH_BAD;
					end
				end
				PH_BAD: begin
					if (b == ChCr) begin
						phase_d = PH_BAD_CR;
					end
				end
				PH_BAD_CR: begin
					if (b == ChLf) begin
						have_verdict = 1'b1;
						status_d     = ST_BAD;
					end else if (b != ChCr) begin
						phase_d = PH_BAD;
					end
				end
				PH_DATA: begin
					// Remaining is never zero here: the size line already checked it
					have_data   = 1'b1;
					remaining_d = remaining_q - 1'b1;
					if (remaining_q == RemW'(1)) begin
						phase_d     = PH_SKIP;
						skip_left_d = SkipCount;
					end
				end
				PH_SKIP: begin
					skip_left_d = skip_left_q - 1'b1;
					if (skip_left_q <= 2'd1) begin
						skip_left_d   = '0;
						phase_d       = PH_SIZE;
						remaining_d   = '0;
						digit_count_d = '0;
					end
				end
				default: begin
					phase_d       = PH_SIZE;
					remaining_d   = '0;
					digit_count_d = '0;
				end
			endcase

			// Body ended before any verdict: report truncation
			if (eob && !have_verdict) begin
				have_verdict = 1'b1;
				status_d     = ST_TRUNC;
			end
			if (have_verdict) begin
				verdict_sent_d = 1'b1;
			end
		end

		// Return to the reset state after the last byte of a body
		if (eob) begin
			phase_d        = PH_SIZE;
			remaining_d    = '0;
			digit_count_d  = '0;
			skip_left_d    = '0;
			verdict_sent_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_SIZE;
			remaining_q    <= '0;
			digit_count_q  <= '0;
			skip_left_q    <= '0;
			verdict_sent_q <= 1'b0;
		end else if (take) begin
			phase_q        <= phase_d;
			remaining_q    <= remaining_d;
			digit_count_q  <= digit_count_d;
			skip_left_q    <= skip_left_d;
			verdict_sent_q <= verdict_sent_d;
		end
	end

	// Load a result when this byte makes one, else drain the slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take && (have_data || have_verdict)) begin
			res_valid_q <= 1'b1;
		end else if (dout.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && (have_data || have_verdict)) begin
			res_byte_q   <= have_data ? b : 8'h00;
			res_data_q   <= have_data;
			res_status_q <= status_d;
			res_last_q   <= have_verdict;
		end
	end

	assign dout.valid     = res_valid_q;
	assign dout.out_byte  = res_byte_q;
	assign dout.out_valid = res_data_q;
	assign dout.status    = res_status_q;
	assign dout.last      = res_last_q;

	// Only a truncation verdict may carry a payload byte
	a_data_status: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid && dout.out_valid |-> (dout.status == ST_RUN || dout.status == ST_TRUNC))
		else $error("payload byte with ok or bad-size status");

	// A result that is not the verdict is a plain payload byte
	a_nonlast_data: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid && !dout.last |-> dout.out_valid && dout.status == ST_RUN)
		else $error("non-final result without payload");

	a_data_remaining: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA && !verdict_sent_q |-> remaining_q != '0)
		else $error("data phase with empty chunk");

	a_skip_left: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_SKIP |-> skip_left_q != '0)
		else $error("skip phase with nothing to skip");

endmodule
